>>> rtl/mspi_pkg.sv
// ----------------------------------------------------------------------------
// mspi_pkg
// Shared widths, register indexes and reset values of the multi-axis speed PI loop.
// ----------------------------------------------------------------------------
package mspi_pkg;

   localparam int AXIS_W     = 3;
   localparam int ERR_W      = 24;
   localparam int OUT_W      = 27;
   localparam int AXES_DEF   = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int PROP_W     = 25;
   localparam int INTEG_W    = 32;
   localparam int INERTIA_W  = 16;

   localparam int GAIN_SHIFT = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_INERTIA_GAIN = 3'd2,
      CSR_OUT_MAX      = 3'd3,
      CSR_OUT_MIN      = 3'd4
   } csr_index_type;

   localparam logic [PROP_W-1:0]    PROP_RST    = PROP_W'(6000000);
   localparam logic [INTEG_W-1:0]   INTEG_RST   = '0;
   localparam logic [INERTIA_W-1:0] INERTIA_RST = INERTIA_W'(1);
   localparam logic [OUT_W-1:0]     OUT_MAX_RST = OUT_W'(33554432);
   localparam logic [OUT_W-1:0]     OUT_MIN_RST = OUT_W'(-33554432);

endpackage

>>> rtl/mspi_req_if.sv
// ----------------------------------------------------------------------------
// mspi_req_if
// Request channel: axis index and speed error.
// ----------------------------------------------------------------------------
interface mspi_req_if;
   logic                               valid;
   logic                               ready;
   logic [mspi_pkg::AXIS_W-1:0]        axis;
   logic signed [mspi_pkg::ERR_W-1:0]  speed_error;

   modport source (output valid, axis, speed_error, input ready);
   modport sink   (input valid, axis, speed_error, output ready);
endinterface

>>> rtl/mspi_rsp_if.sv
// ----------------------------------------------------------------------------
// mspi_rsp_if
// Response channel: clamped drive value and integrator.
// ----------------------------------------------------------------------------
interface mspi_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mspi_pkg::OUT_W-1:0]  drive_out;
   logic signed [mspi_pkg::OUT_W-1:0]  integral_now;

   modport source (output valid, drive_out, integral_now, input ready);
   modport sink   (input valid, drive_out, integral_now, output ready);
endinterface

>>> rtl/mspi_csr_if.sv
// ----------------------------------------------------------------------------
// mspi_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mspi_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mspi_pkg::CSR_IDX_W-1:0]      index;
   logic [mspi_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

>>> rtl/multi_axis_speed_pi_loop.sv
// ----------------------------------------------------------------------------
// multi_axis_speed_pi_loop
// Fixed-point PI speed regulator shared by several axes, one integrator each.
// ----------------------------------------------------------------------------
// One request runs from acceptance to a valid response as follows: one 32x16
// multiplier is reused for error times inertia and then for three partial
// products per gain, followed by a term, an integrator and a drive step.
// The request channel is ready again in the same cycle as the response becomes
// valid, so a new request is taken only after the last one has finished. A finished
// response waits in the output register while the next request is taken; that
// request then holds at its drive step until the output register is free.
// Register writes are accepted in every cycle and must be made while the
// block is idle. Axis indexes at or above AXES wrap modulo AXES.
// ----------------------------------------------------------------------------
module multi_axis_speed_pi_loop #(
   parameter int AXES = mspi_pkg::AXES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mspi_req_if.sink    req_ch,
   mspi_rsp_if.source  rsp_ch,
   mspi_csr_if.sink    csr_ch
);

   localparam int AXIDX_W   = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int OUT_W     = mspi_pkg::OUT_W;
   localparam int MUL_A_W   = 32;
   localparam int CHUNK_W   = 16;
   localparam int PROD_W    = MUL_A_W + CHUNK_W;
   localparam int MAG_W     = 3 * CHUNK_W;
   localparam int ACC_W     = MAG_W + MUL_A_W;
   localparam int TMAG_W    = 29;
   localparam int TERM_W    = TMAG_W + 1;
   localparam int SUM_W     = TERM_W + 1;
   localparam logic [ACC_W-1:0] TERM_LIM = ACC_W'(1) << (TMAG_W - 1);
   localparam logic [ACC_W-1:0] REM_MASK =
      (ACC_W'(1) << mspi_pkg::GAIN_SHIFT) - ACC_W'(1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MAG   = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_TERM  = 7'b0001000,
      S_ACC   = 7'b0010000,
      S_DRIVE = 7'b0100000,
      S_HOLD  = 7'b1000000
   } state_type;

   function automatic logic [AXIDX_W-1:0] axis_wrap(input logic [mspi_pkg::AXIS_W-1:0] a);
      logic [6:0] v;
      v = 7'(a);
      for (int i = 0; i < 8; i++) begin
         if (v >= 7'(AXES)) begin
            v = v - 7'(AXES);
         end
      end
      return AXIDX_W'(v);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp(
      input logic signed [SUM_W-1:0] v,
      input logic signed [OUT_W-1:0] hi,
      input logic signed [OUT_W-1:0] lo
   );
      logic signed [SUM_W-1:0] r;
      r = v;
      if (r > SUM_W'(hi)) begin
         r = SUM_W'(hi);
      end
      if (r < SUM_W'(lo)) begin
         r = SUM_W'(lo);
      end
      return r[OUT_W-1:0];
   endfunction

   // state and config
   state_type state_ff, state_in;
   logic [1:0]                            cnt_ff, cnt_in;
   logic                                  phase_ff, phase_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [AXES-1:0]                       vld_ff, vld_in;
   logic [mspi_pkg::PROP_W-1:0]           prop_ff;
   logic [mspi_pkg::INTEG_W-1:0]          integ_ff;
   logic [mspi_pkg::INERTIA_W-1:0]        inertia_ff;
   logic signed [OUT_W-1:0]               max_ff, min_ff;

   // datapath
   logic [AXIDX_W-1:0]                    axis_ff, axis_in;
   logic                                  neg_ff, neg_in;
   logic [mspi_pkg::ERR_W-1:0]            emag_ff, emag_in;
   logic [MAG_W-1:0]                      mag_ff, mag_in;
   logic [ACC_W-1:0]                      acc_ff, acc_in;
   logic signed [TERM_W-1:0]              pterm_ff, pterm_in;
   logic signed [TERM_W-1:0]              iterm_ff, iterm_in;
   logic signed [OUT_W-1:0]               integ_rd_ff;
   logic                                  integ_ok_ff;
   logic signed [OUT_W-1:0]               acc_val_ff, acc_val_in;
   logic signed [OUT_W-1:0]               drive_ff, drive_in;
   logic signed [OUT_W-1:0]               integ_out_ff, integ_out_in;
   logic signed [OUT_W-1:0]               integ_mem [AXES];

   // shared multiplier
   logic [MUL_A_W-1:0]                    mul_a;
   logic [CHUNK_W-1:0]                    mul_b;
   logic [PROD_W-1:0]                     mul_p;

   logic [ACC_W-1:0]                      q;
   logic                                  rem_nz;
   logic [TMAG_W-1:0]                     tmag;
   logic signed [TERM_W-1:0]              term;
   logic signed [OUT_W-1:0]               integ_cur;
   logic                                  req_fire;
   logic                                  out_free;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign req_fire            = req_ch.valid && req_ch.ready;
   assign csr_ch.ready        = 1'b1;
   assign out_free            = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.drive_out    = drive_ff;
   assign rsp_ch.integral_now = integ_out_ff;

   always_comb begin
      if (state_ff == S_MAG) begin
         mul_a = MUL_A_W'(emag_ff);
         mul_b = inertia_ff;
      end else begin
         mul_a = phase_ff ? integ_ff : MUL_A_W'(prop_ff);
         mul_b = mag_ff[CHUNK_W*cnt_ff +: CHUNK_W];
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      q      = acc_ff >> mspi_pkg::GAIN_SHIFT;
      rem_nz = |(acc_ff & REM_MASK);
      tmag   = (q > TERM_LIM) ? TMAG_W'(TERM_LIM) : q[TMAG_W-1:0];
      if (neg_ff) begin
         term = -$signed({1'b0, tmag + TMAG_W'(rem_nz)});
      end else begin
         term = $signed({1'b0, tmag});
      end
      integ_cur = integ_ok_ff ? integ_rd_ff : '0;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      vld_in       = vld_ff;
      axis_in      = axis_ff;
      neg_in       = neg_ff;
      emag_in      = emag_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      pterm_in     = pterm_ff;
      iterm_in     = iterm_ff;
      acc_val_in   = acc_val_ff;
      drive_in     = drive_ff;
      integ_out_in = integ_out_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               axis_in  = axis_wrap(req_ch.axis);
               neg_in   = req_ch.speed_error[mspi_pkg::ERR_W-1];
               emag_in  = neg_in ? -req_ch.speed_error : req_ch.speed_error;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            mag_in   = MAG_W'(mul_p);
            acc_in   = '0;
            cnt_in   = '0;
            phase_in = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = acc_ff + (ACC_W'(mul_p) << (CHUNK_W * cnt_ff));
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            cnt_in = '0;
            acc_in = '0;
            if (!phase_ff) begin
               pterm_in = term;
               phase_in = 1'b1;
               state_in = S_MUL;
            end else begin
               iterm_in = term;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_val_in = clamp(SUM_W'(integ_cur) + SUM_W'(iterm_ff), max_ff, min_ff);
            vld_in[axis_ff] = 1'b1;
            state_in = S_DRIVE;
         end
         S_DRIVE: begin
            if (out_free) begin
               drive_in     = clamp(SUM_W'(pterm_ff) + SUM_W'(acc_val_ff), max_ff, min_ff);
               integ_out_in = acc_val_ff;
               state_in     = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         prop_ff      <= mspi_pkg::PROP_RST;
         integ_ff     <= mspi_pkg::INTEG_RST;
         inertia_ff   <= mspi_pkg::INERTIA_RST;
         max_ff       <= mspi_pkg::OUT_MAX_RST;
         min_ff       <= mspi_pkg::OUT_MIN_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               mspi_pkg::CSR_PROP_GAIN:    prop_ff    <= csr_ch.wdata[mspi_pkg::PROP_W-1:0];
               mspi_pkg::CSR_INTEG_GAIN:   integ_ff   <= csr_ch.wdata[mspi_pkg::INTEG_W-1:0];
               mspi_pkg::CSR_INERTIA_GAIN: inertia_ff <= csr_ch.wdata[mspi_pkg::INERTIA_W-1:0];
               mspi_pkg::CSR_OUT_MAX:      max_ff     <= csr_ch.wdata[OUT_W-1:0];
               mspi_pkg::CSR_OUT_MIN:      min_ff     <= csr_ch.wdata[OUT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      neg_ff       <= neg_in;
      emag_ff      <= emag_in;
      mag_ff       <= mag_in;
      acc_ff       <= acc_in;
      pterm_ff     <= pterm_in;
      iterm_ff     <= iterm_in;
      acc_val_ff   <= acc_val_in;
      drive_ff     <= drive_in;
      integ_out_ff <= integ_out_in;
   end

   // integrator store: registered read during the first multiply, write after clamp
   always_ff @(posedge clock) begin
      if (state_ff == S_MAG) begin
         integ_rd_ff <= integ_mem[axis_ff];
         integ_ok_ff <= vld_ff[axis_ff];
      end
      if (state_ff == S_ACC) begin
         integ_mem[axis_ff] <= acc_val_in;
      end
   end

endmodule
